// ----- hdl/pdms_pkg.sv -----
// Shared constants, types and control records for the path densifier and smoother.
package pdms_pkg;

    // Store and coordinate sizing
    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int COORD_W    = 24;
    localparam int POINT_W    = 2 * COORD_W;
    localparam int SPACING_W  = 24;
    localparam logic [SPACING_W-1:0] SPACING_RESET = 24'd256;

    // Smoothing window rules
    localparam int MIN_SMOOTH = 25;
    localparam int WIDE_LIMIT = 40;
    localparam int HALF_WIDE  = 20;
    localparam int HALF_NARROW = 10;
    localparam int M_W   = 5;
    localparam int TAP_W = M_W + 1;

    // Arithmetic units
    localparam int DIV_NUM_W   = 32;
    localparam int DIV_DEN_W   = 25;
    localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);
    localparam int SQRT_ROOT_W = 25;
    localparam int SQRT_RAD_W  = 2 * SQRT_ROOT_W;
    localparam int SQRT_REM_W  = SQRT_ROOT_W + 3;
    localparam int SQRT_CNT_W  = $clog2(SQRT_ROOT_W);
    localparam int ACC_W       = 32;

    // Stream field positions
    localparam int TDATA_W = POINT_W;
    localparam int OUT_USER_W = 2;
    localparam int USER_OVF = 0;
    localparam int USER_NR  = 1;
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SQUARE,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_K_GO,
        ST_K_WAIT,
        ST_DX_GO,
        ST_DX_WAIT,
        ST_DY_GO,
        ST_DY_WAIT,
        ST_INTERP,
        ST_ANCHOR,
        ST_PLAIN_RD,
        ST_PLAIN_GET,
        ST_ACC,
        ST_ACC_DRAIN,
        ST_SX_GO,
        ST_SX_WAIT,
        ST_SY_GO,
        ST_SY_WAIT,
        ST_EMIT,
        ST_EMPTY
    } pdms_state_t;

    typedef enum logic [2:0] {
        DIV_K,
        DIV_DX,
        DIV_DY,
        DIV_SX,
        DIV_SY
    } pdms_div_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic          latch;
        logic          square;
        logic          sqrt_start;
        logic          div_start;
        logic          div_latch;
        pdms_div_sel_t div_sel;
        logic          interp_write;
        logic          set_ovf;
        logic          anchor_write;
        logic          acc_clear;
        logic          acc_read;
        logic          plain_get;
        logic          emit;
        logic          emit_empty;
    } pdms_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mode;
        logic path_ready;
        logic have_point;
        logic count_nz;
        logic full;
        logic k_small;
        logic i_done;
        logic plain;
        logic tap_last;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } pdms_status_t;

endpackage

// ----- hdl/pdms_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
module pdms_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [pdms_pkg::DIV_NUM_W-1:0]       num,
    input  logic [pdms_pkg::DIV_DEN_W-1:0]       den,
    output logic                                 done,
    output logic [pdms_pkg::DIV_NUM_W-1:0]       quo,
    output logic [pdms_pkg::DIV_DEN_W-1:0]       rem
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [pdms_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [pdms_pkg::DIV_NUM_W-1:0]     quo_reg;
    logic [pdms_pkg::DIV_DEN_W-1:0]     rem_reg;
    logic [pdms_pkg::DIV_DEN_W-1:0]     den_reg;
    logic [pdms_pkg::DIV_DEN_W:0]       trial;
    logic                               fits;

    // Shift in the next numerator bit and try a subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[pdms_pkg::DIV_NUM_W-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pdms_pkg::DIV_CNT_W'(pdms_pkg::DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? pdms_pkg::DIV_DEN_W'(trial - {1'b0, den_reg})
                            : trial[pdms_pkg::DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[pdms_pkg::DIV_NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- hdl/pdms_isqrt.sv -----
// Serial integer square root, one root bit per cycle.
module pdms_isqrt
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [pdms_pkg::SQRT_RAD_W-1:0]      rad,
    output logic                                 done,
    output logic [pdms_pkg::SQRT_ROOT_W-1:0]     root
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [pdms_pkg::SQRT_CNT_W-1:0]     cnt_reg;
    logic [pdms_pkg::SQRT_RAD_W-1:0]     rad_reg;
    logic [pdms_pkg::SQRT_ROOT_W-1:0]    root_reg;
    logic [pdms_pkg::SQRT_REM_W-1:0]     rem_reg;
    logic [pdms_pkg::SQRT_REM_W-1:0]     pair;
    logic [pdms_pkg::SQRT_REM_W-1:0]     trial;
    logic                                fits;

    // Bring down two radicand bits, test root*4+1
    always_comb
    begin
        pair  = {rem_reg[pdms_pkg::SQRT_REM_W-3:0],
                 rad_reg[pdms_pkg::SQRT_RAD_W-1 -: 2]};
        trial = {1'b0, root_reg, 2'b01};
        fits  = pair >= trial;
    end

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pdms_pkg::SQRT_CNT_W'(pdms_pkg::SQRT_ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Root, remainder and radicand shifter
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[pdms_pkg::SQRT_RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? pair - trial : pair;
            root_reg <= {root_reg[pdms_pkg::SQRT_ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- hdl/pdms_ctrl.sv -----
// Controller state machine: sequences anchor loads and result fetches.
module pdms_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  pdms_pkg::pdms_status_t status,
    output pdms_pkg::pdms_cmd_t    cmd
);

    pdms_pkg::pdms_state_t state_reg;
    pdms_pkg::pdms_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pdms_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = pdms_pkg::DIV_K;
        s_tready    = 1'b0;
        unique case (state_reg)
            pdms_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
                if (s_tvalid)
                    state_next = pdms_pkg::ST_DISPATCH;
            end
            pdms_pkg::ST_DISPATCH:
            begin
                if (status.mode == pdms_pkg::MODE_LOAD)
                    state_next = status.count_nz ? pdms_pkg::ST_SQUARE : pdms_pkg::ST_ANCHOR;
                else if (!(status.path_ready && status.have_point))
                    state_next = pdms_pkg::ST_EMPTY;
                else if (status.plain)
                    state_next = pdms_pkg::ST_PLAIN_RD;
                else
                begin
                    cmd.acc_clear = 1'b1;
                    state_next    = pdms_pkg::ST_ACC;
                end
            end
            pdms_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = pdms_pkg::ST_SQRT_GO;
            end
            pdms_pkg::ST_SQRT_GO:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = pdms_pkg::ST_SQRT_WAIT;
            end
            pdms_pkg::ST_SQRT_WAIT:
            begin
                if (status.sqrt_done)
                    state_next = pdms_pkg::ST_K_GO;
            end
            pdms_pkg::ST_K_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = pdms_pkg::ST_K_WAIT;
            end
            pdms_pkg::ST_K_WAIT:
            begin
                cmd.div_latch = status.div_done;
                if (status.div_done)
                    state_next = pdms_pkg::ST_DX_GO;
            end
            pdms_pkg::ST_DX_GO:
            begin
                cmd.div_sel = pdms_pkg::DIV_DX;
                if (status.k_small)
                    state_next = pdms_pkg::ST_ANCHOR;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = pdms_pkg::ST_DX_WAIT;
                end
            end
            pdms_pkg::ST_DX_WAIT:
            begin
                cmd.div_sel   = pdms_pkg::DIV_DX;
                cmd.div_latch = status.div_done;
                if (status.div_done)
                    state_next = pdms_pkg::ST_DY_GO;
            end
            pdms_pkg::ST_DY_GO:
            begin
                cmd.div_sel   = pdms_pkg::DIV_DY;
                cmd.div_start = 1'b1;
                state_next    = pdms_pkg::ST_DY_WAIT;
            end
            pdms_pkg::ST_DY_WAIT:
            begin
                cmd.div_sel   = pdms_pkg::DIV_DY;
                cmd.div_latch = status.div_done;
                if (status.div_done)
                    state_next = pdms_pkg::ST_INTERP;
            end
            pdms_pkg::ST_INTERP:
            begin
                if (status.i_done)
                    state_next = pdms_pkg::ST_ANCHOR;
                else if (status.full)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = pdms_pkg::ST_ANCHOR;
                end
                else
                    cmd.interp_write = 1'b1;
            end
            pdms_pkg::ST_ANCHOR:
            begin
                cmd.anchor_write = 1'b1;
                state_next       = pdms_pkg::ST_IDLE;
            end
            pdms_pkg::ST_PLAIN_RD:
            begin
                state_next = pdms_pkg::ST_PLAIN_GET;
            end
            pdms_pkg::ST_PLAIN_GET:
            begin
                cmd.plain_get = 1'b1;
                state_next    = pdms_pkg::ST_EMIT;
            end
            pdms_pkg::ST_ACC:
            begin
                cmd.acc_read = 1'b1;
                if (status.tap_last)
                    state_next = pdms_pkg::ST_ACC_DRAIN;
            end
            pdms_pkg::ST_ACC_DRAIN:
            begin
                state_next = pdms_pkg::ST_SX_GO;
            end
            pdms_pkg::ST_SX_GO:
            begin
                cmd.div_sel   = pdms_pkg::DIV_SX;
                cmd.div_start = 1'b1;
                state_next    = pdms_pkg::ST_SX_WAIT;
            end
            pdms_pkg::ST_SX_WAIT:
            begin
                cmd.div_sel   = pdms_pkg::DIV_SX;
                cmd.div_latch = status.div_done;
                if (status.div_done)
                    state_next = pdms_pkg::ST_SY_GO;
            end
            pdms_pkg::ST_SY_GO:
            begin
                cmd.div_sel   = pdms_pkg::DIV_SY;
                cmd.div_start = 1'b1;
                state_next    = pdms_pkg::ST_SY_WAIT;
            end
            pdms_pkg::ST_SY_WAIT:
            begin
                cmd.div_sel   = pdms_pkg::DIV_SY;
                cmd.div_latch = status.div_done;
                if (status.div_done)
                    state_next = pdms_pkg::ST_EMIT;
            end
            pdms_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = pdms_pkg::ST_IDLE;
                end
            end
            pdms_pkg::ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = pdms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pdms_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/pdms_datapath.sv -----
// Datapath: point store, segment measure, interpolation, window sums and output register.
module pdms_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pdms_pkg::pdms_cmd_t                   cmd,
    output pdms_pkg::pdms_status_t                status,
    input  logic [pdms_pkg::TDATA_W-1:0]          s_tdata,
    input  logic                                  s_tuser,
    input  logic                                  s_tlast,
    input  logic                                  cfg_valid,
    input  logic [pdms_pkg::SPACING_W-1:0]        cfg_data,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [pdms_pkg::TDATA_W-1:0]          m_tdata,
    output logic [pdms_pkg::OUT_USER_W-1:0]       m_tuser,
    output logic                                  m_tlast
);

    localparam int CW = pdms_pkg::COORD_W;
    localparam int AW = pdms_pkg::ADDR_W;
    localparam int NW = pdms_pkg::CNT_W;
    localparam int DW = pdms_pkg::DIV_DEN_W;
    localparam int QW = pdms_pkg::DIV_NUM_W;

    // Dense point store
    logic [pdms_pkg::POINT_W-1:0] mem [pdms_pkg::MAX_POINTS];
    logic [pdms_pkg::POINT_W-1:0] rdata_reg;
    logic [AW-1:0]                rd_addr;
    logic [pdms_pkg::POINT_W-1:0] wr_data;
    logic                         wr_en;

    // Transaction and path state
    logic [CW-1:0]  x_reg, y_reg, prev_x_reg, prev_y_reg;
    logic           mode_reg, last_reg;
    logic [NW-1:0]  count_reg, rp_reg;
    logic           ovf_reg, ready_reg;
    logic [pdms_pkg::SPACING_W-1:0] spacing_reg;

    // Segment measure and interpolation
    logic [2*CW-1:0] ux2_reg, uy2_reg;
    logic [DW-1:0]   k_reg, i_reg;
    logic [DW-1:0]   qdx_reg, rdx_reg, qdy_reg, rdy_reg;
    logic [DW-1:0]   qx_reg, rx_reg, qy_reg, ry_reg;

    // Window sums
    logic signed [pdms_pkg::ACC_W-1:0] acc_x_reg, acc_y_reg;
    logic [pdms_pkg::TAP_W-1:0]        tap_reg;
    logic                              pend_reg;
    logic [CW-1:0]                     res_x_reg, res_y_reg;

    // Output register
    logic           out_valid_reg, out_last_reg, out_ovf_reg, out_nr_reg;
    logic [CW-1:0]  out_x_reg, out_y_reg;

    // Arithmetic unit hookup
    logic [QW-1:0]                     div_num, div_quo, rnd;
    logic [DW-1:0]                     div_den, div_rem;
    logic                              div_done;
    logic [pdms_pkg::SQRT_ROOT_W-1:0]  root;
    logic                              sqrt_done;

    // Combinational helpers
    logic signed [CW:0]  dxw, dyw;
    logic [CW-1:0]       ux, uy;
    logic [DW:0]         sum_rx, sum_ry;
    logic                wrap_x, wrap_y;
    logic [DW-1:0]       nrx, nry, nqx, nqy, rndx, rndy;
    logic [CW-1:0]       px, py;
    logic [NW-1:0]       dist_hi, half_w, m_min;
    logic [pdms_pkg::M_W-1:0]   m_val;
    logic [pdms_pkg::TAP_W-1:0] m2;
    logic [AW-1:0]       tap_off, tap_addr;
    logic                sx_neg, sy_neg;
    logic [QW-1:0]       sx_mag, sy_mag;
    logic [CW-1:0]       rnd_c, srnd;
    logic                end_pt;

    pdms_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    pdms_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .rad   (pdms_pkg::SQRT_RAD_W'({1'b0, ux2_reg} + {1'b0, uy2_reg})),
        .done  (sqrt_done),
        .root  (root)
    );

    // Segment deltas and magnitudes
    always_comb
    begin
        dxw = $signed({x_reg[CW-1], x_reg}) - $signed({prev_x_reg[CW-1], prev_x_reg});
        dyw = $signed({y_reg[CW-1], y_reg}) - $signed({prev_y_reg[CW-1], prev_y_reg});
        ux  = dxw[CW] ? CW'(-dxw) : dxw[CW-1:0];
        uy  = dyw[CW] ? CW'(-dyw) : dyw[CW-1:0];
    end

    // Window size, tap address and sum magnitudes for the point at the read pointer
    always_comb
    begin
        dist_hi = count_reg - NW'(1) - rp_reg;
        half_w  = (count_reg > NW'(pdms_pkg::WIDE_LIMIT)) ? NW'(pdms_pkg::HALF_WIDE)
                                                          : NW'(pdms_pkg::HALF_NARROW);
        m_min   = rp_reg;
        if (dist_hi < m_min)
            m_min = dist_hi;
        if (half_w < m_min)
            m_min = half_w;
        m_val   = m_min[pdms_pkg::M_W-1:0] + 1'b1;
        m2      = {m_val, 1'b0};
        tap_off = AW'(tap_reg[pdms_pkg::TAP_W-1:1]);
        tap_addr = tap_reg[0] ? rp_reg[AW-1:0] + tap_off : rp_reg[AW-1:0] - tap_off;
        sx_neg  = acc_x_reg[pdms_pkg::ACC_W-1];
        sy_neg  = acc_y_reg[pdms_pkg::ACC_W-1];
        sx_mag  = sx_neg ? QW'(-acc_x_reg) : QW'(acc_x_reg);
        sy_mag  = sy_neg ? QW'(-acc_y_reg) : QW'(acc_y_reg);
    end

    // Divider operand select
    always_comb
    begin
        unique case (cmd.div_sel)
            pdms_pkg::DIV_K:
            begin
                div_num = QW'(root);
                div_den = (spacing_reg == '0) ? DW'(1) : DW'(spacing_reg);
            end
            pdms_pkg::DIV_DX:
            begin
                div_num = QW'(ux);
                div_den = k_reg;
            end
            pdms_pkg::DIV_DY:
            begin
                div_num = QW'(uy);
                div_den = k_reg;
            end
            pdms_pkg::DIV_SX:
            begin
                div_num = sx_mag;
                div_den = DW'(m2);
            end
            default:
            begin
                div_num = sy_mag;
                div_den = DW'(m2);
            end
        endcase
        // Round half away from zero on the magnitude
        rnd   = div_quo + QW'({div_rem, 1'b0} >= {1'b0, div_den});
        rnd_c = rnd[CW-1:0];
        srnd  = (cmd.div_sel == pdms_pkg::DIV_SX) ? (sx_neg ? -rnd_c : rnd_c)
                                                  : (sy_neg ? -rnd_c : rnd_c);
    end

    // Next interpolated point: running quotient and remainder of d*i/k
    always_comb
    begin
        sum_rx = {1'b0, rx_reg} + {1'b0, rdx_reg};
        sum_ry = {1'b0, ry_reg} + {1'b0, rdy_reg};
        wrap_x = sum_rx >= {1'b0, k_reg};
        wrap_y = sum_ry >= {1'b0, k_reg};
        nrx    = wrap_x ? DW'(sum_rx - {1'b0, k_reg}) : sum_rx[DW-1:0];
        nry    = wrap_y ? DW'(sum_ry - {1'b0, k_reg}) : sum_ry[DW-1:0];
        nqx    = qx_reg + qdx_reg + DW'(wrap_x);
        nqy    = qy_reg + qdy_reg + DW'(wrap_y);
        rndx   = nqx + DW'({nrx, 1'b0} >= {1'b0, k_reg});
        rndy   = nqy + DW'({nry, 1'b0} >= {1'b0, k_reg});
        px     = prev_x_reg + (dxw[CW] ? -rndx[CW-1:0] : rndx[CW-1:0]);
        py     = prev_y_reg + (dyw[CW] ? -rndy[CW-1:0] : rndy[CW-1:0]);
    end

    // Store port controls
    always_comb
    begin
        wr_en   = cmd.interp_write || (cmd.anchor_write && !status.full);
        wr_data = cmd.interp_write ? {py, px} : {y_reg, x_reg};
        rd_addr = cmd.acc_read ? tap_addr : rp_reg[AW-1:0];
        end_pt  = (rp_reg + NW'(1)) == count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[AW-1:0]] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    // Status to the controller
    always_comb
    begin
        status.mode       = mode_reg;
        status.path_ready = ready_reg;
        status.have_point = rp_reg < count_reg;
        status.count_nz   = count_reg != '0;
        status.full       = count_reg == NW'(pdms_pkg::MAX_POINTS);
        status.k_small    = k_reg < DW'(2);
        status.i_done     = i_reg >= k_reg;
        status.plain      = (count_reg < NW'(pdms_pkg::MIN_SMOOTH)) || (rp_reg == '0) || end_pt;
        status.tap_last   = tap_reg == (m2 - 1'b1);
        status.sqrt_done  = sqrt_done;
        status.div_done   = div_done;
        status.out_free   = !out_valid_reg || m_tready;
    end

    // Path control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rp_reg        <= '0;
            ovf_reg       <= 1'b0;
            ready_reg     <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            spacing_reg   <= pdms_pkg::SPACING_RESET;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                spacing_reg <= cfg_data;
            pend_reg <= cmd.acc_read;
            // A load after a finished path starts a new one
            if (cmd.latch && (s_tuser == pdms_pkg::MODE_LOAD) && ready_reg)
            begin
                count_reg <= '0;
                rp_reg    <= '0;
                ovf_reg   <= 1'b0;
                ready_reg <= 1'b0;
            end
            if (cmd.interp_write)
                count_reg <= count_reg + 1'b1;
            if (cmd.set_ovf)
                ovf_reg <= 1'b1;
            if (cmd.anchor_write)
            begin
                if (status.full)
                    ovf_reg <= 1'b1;
                else
                    count_reg <= count_reg + 1'b1;
                prev_x_reg <= x_reg;
                prev_y_reg <= y_reg;
                if (last_reg)
                begin
                    ready_reg <= 1'b1;
                    rp_reg    <= '0;
                end
            end
            if (cmd.emit)
            begin
                if (end_pt)
                begin
                    count_reg <= '0;
                    rp_reg    <= '0;
                    ovf_reg   <= 1'b0;
                    ready_reg <= 1'b0;
                end
                else
                    rp_reg <= rp_reg + 1'b1;
            end
            // Output slot
            if (cmd.emit || cmd.emit_empty)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            x_reg    <= s_tdata[CW-1:0];
            y_reg    <= s_tdata[2*CW-1:CW];
            mode_reg <= s_tuser;
            last_reg <= s_tlast;
        end
        if (cmd.square)
        begin
            ux2_reg <= ux * ux;
            uy2_reg <= uy * uy;
        end
        // Divider results
        if (cmd.div_latch)
        begin
            unique case (cmd.div_sel)
                pdms_pkg::DIV_K:
                begin
                    k_reg  <= div_quo[DW-1:0];
                    i_reg  <= DW'(1);
                    qx_reg <= '0;
                    rx_reg <= '0;
                    qy_reg <= '0;
                    ry_reg <= '0;
                end
                pdms_pkg::DIV_DX:
                begin
                    qdx_reg <= div_quo[DW-1:0];
                    rdx_reg <= div_rem;
                end
                pdms_pkg::DIV_DY:
                begin
                    qdy_reg <= div_quo[DW-1:0];
                    rdy_reg <= div_rem;
                end
                pdms_pkg::DIV_SX:
                    res_x_reg <= srnd;
                default:
                    res_y_reg <= srnd;
            endcase
        end
        if (cmd.interp_write)
        begin
            qx_reg <= nqx;
            rx_reg <= nrx;
            qy_reg <= nqy;
            ry_reg <= nry;
            i_reg  <= i_reg + 1'b1;
        end
        // Window accumulation, one store read per cycle
        if (cmd.acc_clear)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            tap_reg   <= '0;
        end
        else
        begin
            if (cmd.acc_read)
                tap_reg <= tap_reg + 1'b1;
            if (pend_reg)
            begin
                acc_x_reg <= acc_x_reg + pdms_pkg::ACC_W'($signed(rdata_reg[CW-1:0]));
                acc_y_reg <= acc_y_reg + pdms_pkg::ACC_W'($signed(rdata_reg[2*CW-1:CW]));
            end
        end
        if (cmd.plain_get)
        begin
            res_x_reg <= rdata_reg[CW-1:0];
            res_y_reg <= rdata_reg[2*CW-1:CW];
        end
        if (cmd.emit)
        begin
            out_x_reg    <= res_x_reg;
            out_y_reg    <= res_y_reg;
            out_last_reg <= end_pt;
            out_ovf_reg  <= ovf_reg;
            out_nr_reg   <= 1'b0;
        end
        else if (cmd.emit_empty)
        begin
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_last_reg <= 1'b0;
            out_ovf_reg  <= 1'b0;
            out_nr_reg   <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;
    always_comb
    begin
        m_tuser = '0;
        m_tuser[pdms_pkg::USER_OVF] = out_ovf_reg;
        m_tuser[pdms_pkg::USER_NR]  = out_nr_reg;
    end

endmodule

// ----- hdl/path_densify_mean_smoother.sv -----
// Top level of the path densifier with moving-average smoother.
//
// Anchors (mode 0) are taken one per transaction. The first anchor of a path is stored
// straight from the dispatch state. A later anchor has its segment measured by a
// bit-serial square root and the shared serial divider. If no point is inserted this
// needs one division. Otherwise three divisions are needed, and the inserted points are
// then written at one per cycle. A fetch (mode 1) computes its point on demand. An
// empty fetch, an end point or a point of a short path needs no division. An interior
// point for a window of m (2 to 21) takes 2m store reads plus two divisions. The store
// reads and the shared divider account for its time. One transaction is worked at a
// time. A result waits in an output register while the next transaction is taken, and
// a fetch stalls only while the previous result is still held there. The spacing
// register may be written whenever the block is idle.
module path_densify_mean_smoother
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration: spacing, unsigned Q16.8
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pdms_pkg::SPACING_W-1:0]       cfg_data,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pdms_pkg::TDATA_W-1:0]         s_tdata,   // pos_x, pos_y
    input  logic                                 s_tuser,   // mode
    input  logic                                 s_tlast,   // final_anchor
    // Output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pdms_pkg::TDATA_W-1:0]         m_tdata,   // out_x, out_y
    output logic [pdms_pkg::OUT_USER_W-1:0]      m_tuser,   // overflowed, nothing_ready
    output logic                                 m_tlast    // end_of_path
);

    pdms_pkg::pdms_cmd_t    cmd;
    pdms_pkg::pdms_status_t status;

    assign cfg_ready = 1'b1;

    pdms_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pdms_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the path densifier and moving-average smoother.
module tb;

    localparam int  LIMIT_CYCLES = 10000000;
    localparam int  SETTLE       = 1500;
    localparam int  CAP          = 1024;

    typedef struct packed {
        logic [23:0] px;
        logic [23:0] py;
        logic        eop;
        logic        ovf;
        logic        none;
    } path_point_t;

    // Path model: densify anchors, smooth on the final one, hand out points
    class path_scoreboard;
        longint dense_x[CAP], dense_y[CAP];
        longint smooth_x[CAP], smooth_y[CAP];
        longint last_x, last_y;
        int     n_points, rd_ptr;
        bit     ovf_flag, path_ready;
        int     spacing;
        path_point_t due[$];
        int     errors, checked, overflows_seen, empties_seen;

        function new();
            last_x = 0; last_y = 0; n_points = 0; rd_ptr = 0;
            ovf_flag = 0; path_ready = 0; spacing = 256;
            errors = 0; checked = 0; overflows_seen = 0; empties_seen = 0;
        endfunction

        function longint div_near(longint num, longint den);
            longint mag, q;
            mag = num < 0 ? -num : num;
            q = (2 * mag + den) / (2 * den);
            return num < 0 ? -q : q;
        endfunction

        function longint seg_length(longint ux, longint uy);
            longint rad, r, c;
            rad = ux * ux + uy * uy;
            r = 0;
            for (int b = 26; b >= 0; b--)
            begin
                c = r | (longint'(1) << b);
                if (c * c <= rad)
                    r = c;
            end
            return r;
        endfunction

        function void push_point(longint x, longint y);
            if (n_points < CAP)
            begin
                dense_x[n_points] = x;
                dense_y[n_points] = y;
                n_points++;
            end
            else
                ovf_flag = 1;
        endfunction

        function void add_anchor(longint x, longint y);
            longint dx, dy, k, sp;
            if (n_points > 0)
            begin
                dx = x - last_x;
                dy = y - last_y;
                sp = spacing != 0 ? spacing : 1;
                k = seg_length(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy) / sp;
                for (longint i = 1; i < k; i++)
                begin
                    if (n_points >= CAP)
                    begin
                        ovf_flag = 1;
                        break;
                    end
                    push_point(last_x + div_near(dx * i, k), last_y + div_near(dy * i, k));
                end
            end
            push_point(x, y);
            last_x = x;
            last_y = y;
        endfunction

        function void smooth_all();
            int hw, m;
            longint sx, sy;
            for (int i = 0; i < n_points; i++)
            begin
                smooth_x[i] = dense_x[i];
                smooth_y[i] = dense_y[i];
            end
            if (n_points < pdms_pkg::MIN_SMOOTH)
                return;
            hw = n_points > pdms_pkg::WIDE_LIMIT ? pdms_pkg::HALF_WIDE : pdms_pkg::HALF_NARROW;
            for (int i = 1; i + 1 < n_points; i++)
            begin
                m = i;
                if (n_points - 1 - i < m) m = n_points - 1 - i;
                if (hw < m) m = hw;
                m++;
                sx = 0;
                sy = 0;
                for (int j = 0; j < m; j++)
                begin
                    sx += dense_x[i - j] + dense_x[i + j];
                    sy += dense_y[i - j] + dense_y[i + j];
                end
                smooth_x[i] = div_near(sx, 2 * m);
                smooth_y[i] = div_near(sy, 2 * m);
            end
        endfunction

        // Accepted input transaction
        function void note_item(logic mode, logic [23:0] x, logic [23:0] y, logic fin);
            path_point_t p;
            if (mode == pdms_pkg::MODE_LOAD)
            begin
                if (path_ready)
                begin
                    path_ready = 0; n_points = 0; rd_ptr = 0; ovf_flag = 0;
                end
                add_anchor(longint'($signed(x)), longint'($signed(y)));
                if (fin)
                begin
                    smooth_all();
                    path_ready = 1;
                    rd_ptr = 0;
                end
                return;
            end
            p = '0;
            if (path_ready && rd_ptr < n_points)
            begin
                p.px  = smooth_x[rd_ptr][23:0];
                p.py  = smooth_y[rd_ptr][23:0];
                p.eop = (rd_ptr + 1 == n_points);
                p.ovf = ovf_flag;
                rd_ptr++;
                if (p.eop)
                begin
                    path_ready = 0; n_points = 0; rd_ptr = 0; ovf_flag = 0;
                end
            end
            else
                p.none = 1;
            due.insert(due.size(), p);
        endfunction

        // Accepted output transaction
        function void check_point(path_point_t got);
            path_point_t want;
            checked++;
            if (due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected output x=%h y=%h", got.px, got.py);
                return;
            end
            want = due.pop_front();
            if (want.ovf) overflows_seen++;
            if (want.none) empties_seen++;
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: point %0d exp x=%h y=%h eop=%b ovf=%b nr=%b, got x=%h y=%h eop=%b ovf=%b nr=%b",
                             checked, want.px, want.py, want.eop, want.ovf, want.none,
                             got.px, got.py, got.eop, got.ovf, got.none);
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [pdms_pkg::SPACING_W-1:0]  cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [pdms_pkg::TDATA_W-1:0]    s_tdata;   // pos_x, pos_y
    logic                            s_tuser;   // mode
    logic                            s_tlast;   // final_anchor
    logic                            m_tvalid;
    logic                            m_tready;
    logic [pdms_pkg::TDATA_W-1:0]    m_tdata;   // out_x, out_y
    logic [pdms_pkg::OUT_USER_W-1:0] m_tuser;   // overflowed, nothing_ready
    logic                            m_tlast;   // end_of_path

    path_scoreboard sb;
    bit     gaps_on;
    bit     hold_req;
    int     n_items, n_paths, n_fetches;
    int     cycles;
    longint cur_x, cur_y;

    path_densify_mean_smoother u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial clk = 0;
    always #4 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output sampling
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_point({m_tdata[23:0], m_tdata[47:24], m_tlast,
                            m_tuser[pdms_pkg::USER_OVF], m_tuser[pdms_pkg::USER_NR]});
    end

    // Receiver with random stalls and one long hold-off on request
    initial
    begin
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                m_tready <= 0;
                repeat (400) @(negedge clk);
                continue;
            end
            if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            m_tready <= 1;
        end
    end

    task automatic send_item(logic mode, logic [23:0] x, logic [23:0] y, logic fin);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= mode;
        s_tdata  <= {y, x};
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(mode, x, y, fin);
        n_items++;
        if (mode == pdms_pkg::MODE_FETCH) n_fetches++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 0;
        while (sb.due.size() != 0)
            @(negedge clk);
    endtask

    // Spacing write, only with the block idle
    task automatic set_spacing(logic [23:0] v);
        drain_results();
        repeat (SETTLE) @(negedge clk);
        cfg_valid <= 1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.spacing = v;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic load_anchor(longint x, longint y, logic fin);
        cur_x = x;
        cur_y = y;
        send_item(pdms_pkg::MODE_LOAD, x[23:0], y[23:0], fin);
        if (fin) n_paths++;
    endtask

    task automatic fetch_points(int cnt);
        for (int i = 0; i < cnt; i++)
            send_item(pdms_pkg::MODE_FETCH, 24'($urandom), 24'($urandom), 1'($urandom));
    endtask

    function automatic longint clamp_coord(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // Well-formed path with random segments of up to reach per axis
    task automatic random_path(int anchors, longint reach);
        int left;
        for (int a = 0; a < anchors; a++)
            load_anchor(clamp_coord(cur_x + longint'($urandom_range(0, 2 * reach)) - reach),
                        clamp_coord(cur_y + longint'($urandom_range(0, 2 * reach)) - reach),
                        a == anchors - 1);
        left = sb.n_points;
        case ($urandom_range(0, 5))
            0:       fetch_points($urandom_range(0, left > 60 ? 60 : left));
            1:       fetch_points(left + $urandom_range(1, 2));
            default: fetch_points(left > 80 ? $urandom_range(20, 80) : left);
        endcase
    endtask

    initial
    begin
        int  sp;
        longint reach;
        sb = new();
        gaps_on = 1;
        hold_req = 0;
        n_items = 0; n_paths = 0; n_fetches = 0; cycles = 0;
        cur_x = 0; cur_y = 0;
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = '0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = pdms_pkg::MODE_LOAD;
        s_tlast = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: fetch before any path, single-point path, fetch after the end
        fetch_points(1);
        load_anchor(-8388608, -8388608, 1);
        fetch_points(2);

        // Largest spacing across full-scale corners
        set_spacing(24'hffffff);
        load_anchor(-8388608, 8388607, 0);
        load_anchor(8388607, -8388608, 1);
        fetch_points(3);

        // Three-anchor path, just long enough to be smoothed
        set_spacing(24'd256);
        load_anchor(0, 0, 0);
        load_anchor(1000, -2000, 0);
        load_anchor(-3000, 500, 1);
        fetch_points(sb.n_points);

        // Narrow window (31 points); anchor load drops the pending results
        load_anchor(0, 0, 0);
        load_anchor(0, 7680, 1);
        fetch_points(5);

        // Wide window (51 points) while the receiver holds off; the next
        // spacing write waits for every result
        load_anchor(0, 0, 0);
        load_anchor(12800, 0, 1);
        hold_req = 1;
        fetch_points(8);

        // Store overflow at the smallest spacing
        set_spacing(24'd1);
        load_anchor(0, 0, 0);
        load_anchor(8388607, 0, 1);
        fetch_points(3);

        // Random part: mostly whole paths, some noise
        sp = 256;
        while (n_items < 1300)
        begin
            if (n_items > 1100)
                gaps_on = 0;
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 7))
                    0:       sp = 1;
                    1:       sp = 24'hffffff;
                    2:       sp = $urandom_range(1, 24'hffffff);
                    default: sp = $urandom_range(8, 2048);
                endcase
                set_spacing(sp[23:0]);
            end
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(1'($urandom), 24'($urandom), 24'($urandom),
                              $urandom_range(0, 3) == 0);
                cur_x = longint'($signed(s_tdata[23:0]));
                cur_y = longint'($signed(s_tdata[47:24]));
                if (sb.path_ready && $urandom_range(0, 1) == 0)
                    fetch_points($urandom_range(1, 6));
            end
            else
            begin
                reach = longint'(sp) * $urandom_range(0, 8);
                if (reach > 8388607) reach = 8388607;
                if (sp == 1 && $urandom_range(0, 3) != 0) reach = $urandom_range(0, 40);
                random_path($urandom_range(1, 12), reach);
            end
        end

        drain_results();
        repeat (300) @(negedge clk);
        $display("covered %0d transactions: %0d paths, %0d fetches, %0d points checked",
                 n_items, n_paths, n_fetches, sb.checked);
        $display("results with overflow set: %0d, empty fetches: %0d",
                 sb.overflows_seen, sb.empties_seen);
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.due.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
